// File: src/pmmu_pkg.sv
// Package for the paging MMU controller: request/result structs, codes, constants.
// No dependencies.
package pmmu_pkg;

  typedef enum logic [2:0] {
    KIND_PORT_WR  = 3'd0,
    KIND_NREG_WR  = 3'd1,
    KIND_NREG_RD  = 3'd2,
    KIND_PORT_RD  = 3'd3,
    KIND_XLATE_RD = 3'd4,
    KIND_XLATE_WR = 3'd5
  } kind_e;

  localparam logic [7:0] PORT_7FFD = 8'd0;
  localparam logic [7:0] PORT_DFFD = 8'd1;
  localparam logic [7:0] PORT_1FFD = 8'd2;
  localparam logic [7:0] PORT_EFF7 = 8'd3;
  localparam logic [7:0] PORT_DFFD_RB = 8'd4;

  localparam logic [7:0] NR_CFG_ROM  = 8'h04;
  localparam logic [7:0] NR_LOCK     = 8'h08;
  localparam logic [7:0] NR_SHADOW   = 8'h69;
  localparam logic [7:0] NR_ALT_ROM  = 8'h8c;
  localparam logic [7:0] NR_PORT_MAP = 8'h8e;
  localparam logic [7:0] NR_PAGING   = 8'h8f;

  localparam logic [0:0] CFG_MACHINE = 1'd0;
  localparam logic [0:0] CFG_CONFIG  = 1'd1;

  localparam logic [1:0] MACH_48K = 2'd1;
  localparam logic [1:0] MACH_P3  = 2'd3;

  localparam logic [20:0] RAM_BASE   = 21'h040000;
  localparam logic [20:0] ALT_ROM_LO = 21'h018000;
  localparam logic [20:0] ALT_ROM_HI = 21'h01c000;
  localparam logic [7:0]  RAM_PAGES  = 8'd224;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  reg_req;
    logic [7:0]  value;
    logic [15:0] address;
  } req_t;

  typedef struct packed {
    logic [7:0]  read_value;
    logic [20:0] physical_offset;
    logic        access_ok;
    logic        write_accepted;
    logic [1:0]  selected_rom;
    logic [6:0]  ram_bank_16k;
    logic        shadow_screen;
  } rsp_t;

  typedef struct packed {
    logic [7:0] p7ffd;
    logic [4:0] pdffd;
    logic       dffd_b6;
    logic [7:0] p1ffd;
    logic [3:0] peff7;
    logic [7:0] alt_rom;
    logic [6:0] cfg_bank;
    logic [7:0] pmode;
  } ports_t;

  function automatic logic [6:0] bank16(input ports_t s);
    logic m1024;
    m1024 = (s.pmode[1:0] == 2'd3) && !s.peff7[2];
    if (s.pmode[1:0] == 2'd2 || m1024)
      bank16 = {1'b0, m1024 & s.p7ffd[5], s.p7ffd[7:6], s.p7ffd[2:0]};
    else
      bank16 = {s.pdffd[3:0], s.p7ffd[2:0]};
  endfunction

  function automatic logic [2:0] rom_sel(input ports_t s, input logic [1:0] mt);
    logic l1, l0, r;
    l1 = s.alt_rom[5];
    l0 = s.alt_rom[4];
    r  = s.p7ffd[4];
    if (mt == MACH_48K)      rom_sel = {2'd0, !(!l1 && l0)};
    else if (mt == MACH_P3) begin
      if (l1 | l0) rom_sel = {l1, l0, l1};
      else         rom_sel = {s.p1ffd[2], r, r};
    end else if (l1 | l0) rom_sel = {1'b0, l1, l1};
    else                  rom_sel = {1'b0, r, r};
  endfunction

endpackage

// File: src/pmmu_state.sv
// Paging state: ports, next registers and slot MMU; applies writes, reloads slots.
// Depends on pmmu_pkg.
module pmmu_state (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                we_i,
  input  pmmu_pkg::req_t      req_i,
  output pmmu_pkg::ports_t    pre_o,
  output logic [7:0]          mmu_pre_o [8],
  output pmmu_pkg::ports_t    ports_o,
  output logic [7:0]          mmu_o [8],
  output logic                acc_o
);
  import pmmu_pkg::*;

  ports_t     s_q, s_d;
  logic [7:0] m_q [8];
  logic [7:0] m_d [8];
  logic       reload, ram_chg, spec_old;
  logic [7:0] v;
  logic [6:0] b;
  logic       b2, b1;
  logic [7:0] hi, up;

  assign v = req_i.value;

  always_comb begin
    s_d = s_q;
    m_d = m_q;
    acc_o = 1'b0;
    reload = 1'b0;
    ram_chg = 1'b1;
    spec_old = 1'b0;
    if (we_i && req_i.kind == KIND_PORT_WR) begin
      if (req_i.reg_req == PORT_EFF7) begin
        s_d.peff7 = {v[3:2], 2'b00};
        reload = 1'b1;
        acc_o = 1'b1;
      end else if (req_i.reg_req <= PORT_1FFD &&
                   (((s_q.pmode[1:0] == 2'd3) && !s_q.peff7[2]) || !s_q.p7ffd[5])) begin
        acc_o = 1'b1;
        reload = 1'b1;
        case (req_i.reg_req)
          PORT_7FFD: s_d.p7ffd = v;
          PORT_DFFD: begin
            s_d.pdffd = v[4:0];
            s_d.dffd_b6 = v[6];
          end
          default: begin
            spec_old = s_q.p1ffd[0];
            s_d.p1ffd = v;
          end
        endcase
      end
    end else if (we_i && req_i.kind == KIND_NREG_WR) begin
      if (req_i.reg_req[7:3] == 5'b01010) m_d[req_i.reg_req[2:0]] = v;
      else case (req_i.reg_req)
        NR_CFG_ROM: s_d.cfg_bank = v[6:0];
        NR_LOCK:    if (v[7]) s_d.p7ffd[5] = 1'b0;
        NR_SHADOW:  s_d.p7ffd[3] = v[6];
        NR_ALT_ROM: s_d.alt_rom = v;
        NR_PORT_MAP: begin
          spec_old = s_q.p1ffd[0];
          if (v[3]) begin
            s_d.p7ffd[2:0] = v[6:4];
            s_d.pdffd = {s_q.pdffd[4], 3'b000, v[7]};
          end
          if (!v[2]) s_d.p7ffd[4] = v[0];
          s_d.p1ffd[2:0] = {v[1], v[0], v[2]};
          ram_chg = v[3];
          reload = 1'b1;
        end
        NR_PAGING: begin
          s_d.pmode = v;
          reload = 1'b1;
        end
        default: ;
      endcase
    end
    b  = bank16(s_d);
    b2 = s_d.p1ffd[2];
    b1 = s_d.p1ffd[1];
    hi = {4'd0, b2 | b1, 3'd0};
    up = {4'd0, !b2 & b1, 3'd0};
    if (reload) begin
      if (s_d.p1ffd[0]) begin
        m_d[0] = hi;
        m_d[1] = hi | 8'd1;
        m_d[2] = hi | {5'd0, b2 & b1, 2'd2};
        m_d[3] = hi | {5'd0, b2 & b1, 2'd3};
        m_d[4] = hi | 8'd4;
        m_d[5] = hi | 8'd5;
        m_d[6] = up | 8'd6;
        m_d[7] = up | 8'd7;
      end else begin
        m_d[0] = s_d.peff7[3] ? 8'h00 : 8'hff;
        m_d[1] = s_d.peff7[3] ? 8'h01 : 8'hff;
        if (spec_old) begin
          m_d[2] = 8'h0a;
          m_d[3] = 8'h0b;
          m_d[4] = 8'h04;
          m_d[5] = 8'h05;
        end
        if (spec_old || ram_chg) begin
          m_d[6] = {b, 1'b0};
          m_d[7] = {b, 1'b1};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_q <= '0;
      m_q[0] <= 8'hff; m_q[1] <= 8'hff; m_q[2] <= 8'h0a; m_q[3] <= 8'h0b;
      m_q[4] <= 8'h04; m_q[5] <= 8'h05; m_q[6] <= 8'h00; m_q[7] <= 8'h01;
    end else begin
      s_q <= s_d;
      m_q <= m_d;
    end
  end

  assign pre_o = s_q;
  assign mmu_pre_o = m_q;
  assign ports_o = s_d;
  assign mmu_o = m_d;
endmodule

// File: src/pmmu_xlate.sv
// Read-back and address translation against the current paging state.
// Depends on pmmu_pkg.
module pmmu_xlate (
  input  pmmu_pkg::req_t    req_i,
  input  pmmu_pkg::ports_t  pre_i,
  input  logic [7:0]        mmu_i [8],
  input  pmmu_pkg::ports_t  post_i,
  input  logic [7:0]        mmu_post_i [8],
  input  logic              acc_i,
  input  logic [1:0]        mach_i,
  input  logic              cfg_mode_i,
  output pmmu_pkg::rsp_t    rsp_o
);
  import pmmu_pkg::*;

  logic [2:0]  slot;
  logic [12:0] low;
  logic [7:0]  page;
  logic [2:0]  rs, rs_post;
  logic [20:0] rom_off, alt_off, off;
  logic        ok, wr;
  logic [7:0]  rd, r8e;

  always_comb begin
    slot = req_i.address[15:13];
    low  = req_i.address[12:0];
    page = mmu_i[slot];
    wr   = (req_i.kind == KIND_XLATE_WR);
    rs   = rom_sel(pre_i, mach_i);
    rs_post = rom_sel(post_i, mach_i);
    rom_off = {5'd0, rs[2:1], slot[0], low};
    alt_off = (rs[0] ? ALT_ROM_HI : ALT_ROM_LO) | {7'd0, slot[0], low};
    off = '0;
    ok = 1'b0;
    if (page < RAM_PAGES) begin
      off = RAM_BASE + {page, low};
      ok = 1'b1;
    end else if (slot <= 3'd1 && cfg_mode_i) begin
      off = {pre_i.cfg_bank, slot[0], low};
      ok = 1'b1;
    end else if (slot > 3'd1 || !pre_i.alt_rom[7]) begin
      if (!wr) begin off = rom_off; ok = 1'b1; end
    end else if (pre_i.alt_rom[6]) begin
      off = wr ? alt_off : rom_off;
      ok = 1'b1;
    end else if (!wr) begin
      off = alt_off;
      ok = 1'b1;
    end
    if (req_i.kind != KIND_XLATE_RD && !wr) begin
      off = '0;
      ok = 1'b0;
    end

    r8e = {pre_i.pdffd[0], pre_i.p7ffd[2:0], 1'b1, pre_i.p1ffd[0], pre_i.p1ffd[2],
           (pre_i.p7ffd[4] & !pre_i.p1ffd[0]) | (pre_i.p1ffd[1] & pre_i.p1ffd[0])};
    rd = '0;
    if (req_i.kind == KIND_NREG_RD) begin
      if (req_i.reg_req[7:3] == 5'b01010) rd = mmu_post_i[req_i.reg_req[2:0]];
      else case (req_i.reg_req)
        NR_CFG_ROM:  rd = {1'b0, pre_i.cfg_bank};
        NR_ALT_ROM:  rd = pre_i.alt_rom;
        NR_PORT_MAP: rd = r8e;
        NR_PAGING:   rd = pre_i.pmode;
        default:     rd = '0;
      endcase
    end else if (req_i.kind == KIND_PORT_RD) begin
      case (req_i.reg_req)
        PORT_7FFD:    rd = pre_i.p7ffd;
        PORT_DFFD:    rd = {3'd0, pre_i.pdffd};
        PORT_1FFD:    rd = pre_i.p1ffd;
        PORT_EFF7:    rd = {4'd0, pre_i.peff7};
        PORT_DFFD_RB: rd = {1'b0, pre_i.dffd_b6, 1'b0, pre_i.pdffd};
        default:      rd = '0;
      endcase
    end

    rsp_o.read_value      = rd;
    rsp_o.physical_offset = off;
    rsp_o.access_ok       = ok;
    rsp_o.write_accepted  = acc_i;
    rsp_o.selected_rom    = rs_post[2:1];
    rsp_o.ram_bank_16k    = bank16(post_i);
    rsp_o.shadow_screen   = post_i.p7ffd[3];
  end
endmodule

// File: src/paging_mmu_controller_top.sv
// Top level of the paging MMU controller: input register, state, translation, result register.
// Depends on pmmu_pkg, pmmu_state, pmmu_xlate.
//
//  channel | signals                       | direction
//  request | req_valid_i req_ready_o req_i | in
//  result  | rsp_valid_o rsp_ready_i rsp_o | out
//  config  | cfg_we_i cfg_idx_i cfg_data_i | in
//
// A request is registered on accept; its result is registered in the output register once
// that is free or taken. One request per cycle sustained while results are taken. State updates
// as the result is registered. Reset clears all ports and loads the default slot map. A stalled
// result holds the pipeline; a bubble in either register is filled.
module paging_mmu_controller_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             req_valid_i,
  output logic             req_ready_o,
  input  pmmu_pkg::req_t   req_i,
  output logic             rsp_valid_o,
  input  logic             rsp_ready_i,
  output pmmu_pkg::rsp_t   rsp_o,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [1:0]       cfg_data_i
);
  import pmmu_pkg::*;

  logic       in_vld_q, out_vld_q, adv;
  req_t       in_q;
  rsp_t       out_q, rsp_d;
  logic [1:0] mach_q;
  logic       cfgm_q;
  ports_t     pre_s, post_s;
  logic [7:0] mmu_pre [8];
  logic [7:0] mmu_post [8];
  logic       acc;

  assign adv = in_vld_q && (!out_vld_q || rsp_ready_i);
  assign req_ready_o = !in_vld_q || adv;

  pmmu_state u_state (
    .clk_i, .rst_ni, .we_i(adv), .req_i(in_q),
    .pre_o(pre_s), .mmu_pre_o(mmu_pre),
    .ports_o(post_s), .mmu_o(mmu_post), .acc_o(acc)
  );

  pmmu_xlate u_xlate (
    .req_i(in_q), .pre_i(pre_s), .mmu_i(mmu_pre), .post_i(post_s),
    .mmu_post_i(mmu_post), .acc_i(acc), .mach_i(mach_q), .cfg_mode_i(cfgm_q),
    .rsp_o(rsp_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      mach_q    <= MACH_P3;
      cfgm_q    <= 1'b0;
    end else begin
      if (req_ready_o) in_vld_q <= req_valid_i;
      if (adv) out_vld_q <= 1'b1;
      else if (rsp_ready_i) out_vld_q <= 1'b0;
      if (cfg_we_i && cfg_idx_i == CFG_MACHINE) mach_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == CFG_CONFIG) cfgm_q <= cfg_data_i[0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_valid_i && req_ready_o) in_q <= req_i;
    if (adv) out_q <= rsp_d;
  end

  assign rsp_valid_o = out_vld_q;
  assign rsp_o = out_q;
endmodule

// File: src/pmmu_checker.sv
// Port-level checks for the paging MMU controller, bound to the top level.
// Depends on pmmu_pkg.
module pmmu_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            req_valid_i,
  input logic            req_ready_o,
  input logic            rsp_valid_o,
  input logic            rsp_ready_i,
  input pmmu_pkg::rsp_t  rsp_o
);
  import pmmu_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("result dropped while stalled");

  a_ok_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_o.access_ok |-> rsp_o.physical_offset == '0)
    else $error("offset without access");

  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !(rsp_o.write_accepted && (rsp_o.access_ok || rsp_o.read_value != '0)))
    else $error("port write result carries other data");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_o |-> req_ready_o)
    else $error("stalled with empty output");
endmodule

bind paging_mmu_controller_top pmmu_checker u_pmmu_checker (.*);

// File: test/paging_mmu_controller_checker.sv
// Scoreboard for the paging MMU controller: predicts each result from accepted requests.
// Depends on pmmu_pkg; instantiated by paging_mmu_controller_top_tb.
module paging_mmu_controller_checker
  import pmmu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       req_valid_i,
  input  logic       req_ready_i,
  input  req_t       req_i,
  input  logic       rsp_valid_i,
  input  logic       rsp_ready_i,
  input  rsp_t       rsp_i,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [1:0] cfg_data_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [1:0] mach;
  logic       cfg_on;
  logic [7:0] p7, p1, altc, pmode;
  logic [4:0] pd;
  logic       d6;
  logic [3:0] pe;
  logic [6:0] cbank;
  logic [7:0] mmu [8];
  rsp_t       expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic is_1024();
    return pmode[1:0] == 2'd3 && !pe[2];
  endfunction

  function automatic logic [6:0] bank_of();
    logic m;
    m = is_1024();
    if (pmode[1:0] == 2'd2 || m) return {1'b0, m & p7[5], p7[7:6], p7[2:0]};
    return {pd[3:0], p7[2:0]};
  endfunction

  function automatic void pick_rom(output logic [1:0] rom, output logic hi);
    logic l1, l0, r;
    l1 = altc[5];
    l0 = altc[4];
    r = p7[4];
    if (mach == MACH_48K) begin
      rom = 2'd0;
      hi = !(!l1 && l0);
    end else if (mach == MACH_P3) begin
      if (l1 | l0) begin
        rom = {l1, l0};
        hi = l1;
      end else begin
        rom = {p1[2], r};
        hi = r;
      end
    end else if (l1 | l0) begin
      rom = {1'b0, l1};
      hi = l1;
    end else begin
      rom = {1'b0, r};
      hi = r;
    end
  endfunction

  function automatic void remap(input logic ram_chg, input logic spec_old);
    logic b2, b1;
    logic [7:0] hi, up;
    logic [6:0] b;
    if (p1[0]) begin
      b2 = p1[2];
      b1 = p1[1];
      hi = {4'd0, b2 | b1, 3'd0};
      up = {4'd0, !b2 & b1, 3'd0};
      mmu[0] = hi;
      mmu[1] = hi | 8'd1;
      mmu[2] = hi | {5'd0, b2 & b1, 2'd0} | 8'd2;
      mmu[3] = mmu[2] | 8'd1;
      mmu[4] = hi | 8'd4;
      mmu[5] = hi | 8'd5;
      mmu[6] = up | 8'd6;
      mmu[7] = up | 8'd7;
    end else begin
      mmu[0] = pe[3] ? 8'h00 : 8'hff;
      mmu[1] = pe[3] ? 8'h01 : 8'hff;
      if (spec_old) begin
        mmu[2] = 8'h0a;
        mmu[3] = 8'h0b;
        mmu[4] = 8'h04;
        mmu[5] = 8'h05;
      end
      if (spec_old || ram_chg) begin
        b = bank_of();
        mmu[6] = {b, 1'b0};
        mmu[7] = {b, 1'b1};
      end
    end
  endfunction

  function automatic logic [7:0] port_map_byte();
    logic sp;
    sp = p1[0];
    return {pd[0], p7[2:0], 1'b1, sp, p1[2], (p7[4] & !sp) | (p1[1] & sp)};
  endfunction

  function automatic rsp_t predict_paging(input req_t rq);
    rsp_t r;
    logic old, hi;
    logic [1:0] rom;
    logic [2:0] slot;
    logic [7:0] pg;
    logic [20:0] rom_off, alt_off, lo;
    r = '0;
    case (rq.kind)
      KIND_PORT_WR: begin
        if (rq.reg_req == PORT_EFF7) begin
          pe = rq.value[3:0] & 4'hc;
          remap(1'b1, 1'b0);
          r.write_accepted = 1'b1;
        end else if (rq.reg_req <= PORT_1FFD && (is_1024() || !p7[5])) begin
          r.write_accepted = 1'b1;
          if (rq.reg_req == PORT_7FFD) begin
            p7 = rq.value;
            remap(1'b1, 1'b0);
          end else if (rq.reg_req == PORT_DFFD) begin
            pd = rq.value[4:0];
            d6 = rq.value[6];
            remap(1'b1, 1'b0);
          end else begin
            old = p1[0];
            p1 = rq.value;
            remap(1'b1, old);
          end
        end
      end
      KIND_NREG_WR: begin
        if (rq.reg_req >= 8'h50 && rq.reg_req <= 8'h57) mmu[rq.reg_req[2:0]] = rq.value;
        else if (rq.reg_req == NR_CFG_ROM) cbank = rq.value[6:0];
        else if (rq.reg_req == NR_LOCK) begin
          if (rq.value[7]) p7[5] = 1'b0;
        end else if (rq.reg_req == NR_SHADOW) p7[3] = rq.value[6];
        else if (rq.reg_req == NR_ALT_ROM) altc = rq.value;
        else if (rq.reg_req == NR_PORT_MAP) begin
          old = p1[0];
          if (rq.value[3]) begin
            p7[2:0] = rq.value[6:4];
            pd = {pd[4], 3'd0, rq.value[7]};
          end
          if (!rq.value[2]) p7[4] = rq.value[0];
          p1[2:0] = {rq.value[1], rq.value[0], rq.value[2]};
          remap(rq.value[3], old);
        end else if (rq.reg_req == NR_PAGING) begin
          pmode = rq.value;
          remap(1'b1, 1'b0);
        end
      end
      KIND_NREG_RD: begin
        if (rq.reg_req >= 8'h50 && rq.reg_req <= 8'h57) r.read_value = mmu[rq.reg_req[2:0]];
        else if (rq.reg_req == NR_CFG_ROM) r.read_value = {1'b0, cbank};
        else if (rq.reg_req == NR_ALT_ROM) r.read_value = altc;
        else if (rq.reg_req == NR_PORT_MAP) r.read_value = port_map_byte();
        else if (rq.reg_req == NR_PAGING) r.read_value = pmode;
      end
      KIND_PORT_RD: begin
        case (rq.reg_req)
          PORT_7FFD:    r.read_value = p7;
          PORT_DFFD:    r.read_value = {3'd0, pd};
          PORT_1FFD:    r.read_value = p1;
          PORT_EFF7:    r.read_value = {4'd0, pe};
          PORT_DFFD_RB: r.read_value = {1'b0, d6, 1'b0, pd};
          default:      r.read_value = 8'd0;
        endcase
      end
      KIND_XLATE_RD, KIND_XLATE_WR: begin
        slot = rq.address[15:13];
        lo = {8'd0, rq.address[12:0]} + (slot[0] ? 21'h2000 : 21'h0);
        pg = mmu[slot];
        if (pg < RAM_PAGES) begin
          r.physical_offset = RAM_BASE + {pg, 13'd0} + {8'd0, rq.address[12:0]};
          r.access_ok = 1'b1;
        end else if (slot <= 3'd1 && cfg_on) begin
          r.physical_offset = {cbank, 14'd0} + lo;
          r.access_ok = 1'b1;
        end else begin
          pick_rom(rom, hi);
          rom_off = {5'd0, rom, 14'd0} + lo;
          alt_off = (hi ? ALT_ROM_HI : ALT_ROM_LO) + lo;
          if (slot > 3'd1 || !altc[7]) begin
            if (rq.kind == KIND_XLATE_RD) begin
              r.physical_offset = rom_off;
              r.access_ok = 1'b1;
            end
          end else if (altc[6]) begin
            r.physical_offset = (rq.kind == KIND_XLATE_WR) ? alt_off : rom_off;
            r.access_ok = 1'b1;
          end else if (rq.kind == KIND_XLATE_RD) begin
            r.physical_offset = alt_off;
            r.access_ok = 1'b1;
          end
        end
      end
      default: ;
    endcase
    pick_rom(rom, hi);
    r.selected_rom = rom;
    r.ram_bank_16k = bank_of();
    r.shadow_screen = p7[3];
    return r;
  endfunction

  task automatic compare_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    rsp_t e;
    if (!rst_ni) begin
      mach = MACH_P3;
      cfg_on = 1'b0;
      p7 = '0; p1 = '0; pd = '0; d6 = '0; pe = '0;
      altc = '0; cbank = '0; pmode = '0;
      mmu = '{8'hff, 8'hff, 8'h0a, 8'h0b, 8'h04, 8'h05, 8'h00, 8'h01};
      expected_q.delete();
      fail_count_o = 0;
      checked_o = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_MACHINE) mach = cfg_data_i;
        else cfg_on = cfg_data_i[0];
      end
      if (req_valid_i && req_ready_i) expected_q.push_back(predict_paging(req_i));
      if (rsp_valid_i && rsp_ready_i) begin
        checked_o++;
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          fail_count_o++;
        end else begin
          e = expected_q.pop_front();
          compare_field("read_value", e.read_value, rsp_i.read_value);
          compare_field("physical_offset", e.physical_offset, rsp_i.physical_offset);
          compare_field("access_ok", e.access_ok, rsp_i.access_ok);
          compare_field("write_accepted", e.write_accepted, rsp_i.write_accepted);
          compare_field("selected_rom", e.selected_rom, rsp_i.selected_rom);
          compare_field("ram_bank_16k", e.ram_bank_16k, rsp_i.ram_bank_16k);
          compare_field("shadow_screen", e.shadow_screen, rsp_i.shadow_screen);
        end
      end
    end
  end
endmodule

// File: test/paging_mmu_controller_top_tb.sv
// Testbench top for paging_mmu_controller_top: clock, reset, request stimulus, verdict.
// Depends on pmmu_pkg, the RTL and paging_mmu_controller_checker.
module paging_mmu_controller_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pmmu_pkg::*;

  logic       clk_i, rst_ni;
  logic       req_valid_i, req_ready_o, rsp_valid_o, rsp_ready_i;
  req_t       req_i;
  rsp_t       rsp_o;
  logic       cfg_we_i, cfg_idx_i;
  logic [1:0] cfg_data_i;
  int         fails, pending, checked, gap;
  int         cycles = 0;

  paging_mmu_controller_top DUT (.*);

  paging_mmu_controller_checker u_chk (
    .clk_i, .rst_ni, .req_valid_i, .req_ready_i(req_ready_o), .req_i,
    .rsp_valid_i(rsp_valid_o), .rsp_ready_i, .rsp_i(rsp_o),
    .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .fail_count_o(fails), .pending_o(pending), .checked_o(checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern: phases of steady accept alternate with random stalling
  always @(posedge clk_i) begin
    if (cycles % 300 < 60) rsp_ready_i <= 1'b1;
    else rsp_ready_i <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_request(input req_t r);
    int idle;
    if (gap == 0) begin
      gap = $urandom_range(1, 12);
      idle = $urandom_range(0, 4);
      if (idle != 0) begin
        req_valid_i <= 1'b0;
        repeat (idle) @(posedge clk_i);
      end
    end
    gap--;
    req_valid_i <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (!req_ready_o);
  endtask

  task automatic drain();
    req_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic idx, input logic [1:0] d);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= d;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic req_t random_request();
    req_t r;
    int sel;
    r.kind = 3'($urandom_range(0, 7));
    r.value = 8'($urandom);
    r.address = 16'($urandom);
    sel = $urandom_range(0, 9);
    if (r.kind == KIND_PORT_WR || r.kind == KIND_PORT_RD)
      r.reg_req = (sel == 0) ? 8'($urandom) : 8'($urandom_range(0, 5));
    else if (sel < 3) r.reg_req = 8'($urandom_range(8'h50, 8'h57));
    else if (sel < 8) begin
      case ($urandom_range(0, 5))
        0: r.reg_req = NR_CFG_ROM;
        1: r.reg_req = NR_LOCK;
        2: r.reg_req = NR_SHADOW;
        3: r.reg_req = NR_ALT_ROM;
        4: r.reg_req = NR_PORT_MAP;
        default: r.reg_req = NR_PAGING;
      endcase
    end else r.reg_req = 8'($urandom);
    if (r.kind >= 3'd4 && sel < 5) r.kind = (sel[0]) ? KIND_XLATE_WR : KIND_XLATE_RD;
    return r;
  endfunction

  initial begin
    req_t r;
    logic [1:0] mset [4] = '{2'd3, 2'd0, 2'd1, 2'd2};
    gap = 0;
    rst_ni = 1'b0;
    req_valid_i = 1'b0;
    req_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_MACHINE;
    cfg_data_i = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: lock, special mode, alt ROM, high pages, unknown kinds and codes
    send_request('{KIND_XLATE_RD, 8'd0, 8'd0, 16'h0000});
    send_request('{KIND_XLATE_WR, 8'd0, 8'd0, 16'hffff});
    send_request('{KIND_PORT_WR, PORT_7FFD, 8'hff, 16'h0});
    send_request('{KIND_PORT_WR, PORT_DFFD, 8'hff, 16'h0});
    send_request('{KIND_NREG_WR, NR_LOCK, 8'h80, 16'h0});
    send_request('{KIND_PORT_WR, PORT_1FFD, 8'h05, 16'h0});
    send_request('{KIND_PORT_WR, PORT_1FFD, 8'h00, 16'h0});
    send_request('{KIND_PORT_WR, PORT_EFF7, 8'hff, 16'h0});
    send_request('{KIND_PORT_WR, PORT_DFFD_RB, 8'h12, 16'h0});
    send_request('{KIND_PORT_RD, PORT_DFFD_RB, 8'h0, 16'h0});
    send_request('{KIND_PORT_RD, 8'hff, 8'h0, 16'h0});
    send_request('{KIND_NREG_WR, NR_PAGING, 8'h03, 16'h0});
    send_request('{KIND_PORT_WR, PORT_7FFD, 8'h20, 16'h0});
    send_request('{KIND_NREG_WR, 8'h57, 8'he0, 16'h0});
    send_request('{KIND_XLATE_WR, 8'd0, 8'd0, 16'hffff});
    send_request('{KIND_NREG_WR, NR_ALT_ROM, 8'hf0, 16'h0});
    send_request('{KIND_XLATE_RD, 8'd0, 8'd0, 16'h2000});
    send_request('{KIND_XLATE_WR, 8'd0, 8'd0, 16'h1fff});
    send_request('{KIND_NREG_WR, NR_PORT_MAP, 8'hff, 16'h0});
    send_request('{KIND_NREG_RD, NR_PORT_MAP, 8'h0, 16'h0});
    send_request('{KIND_NREG_WR, NR_SHADOW, 8'h40, 16'h0});
    send_request('{3'd6, 8'hff, 8'hff, 16'hffff});
    send_request('{3'd7, 8'h0, 8'h0, 16'h0});
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(CFG_MACHINE, mset[ph % 4]);
      write_cfg(CFG_CONFIG, 2'(ph / 4));
      for (int n = 0; n < 135; n++) send_request(random_request());
      drain();
    end

    drain();
    $display("run covered %0d results over all machine types, config mode on and off",
             checked);
    if (fails == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
